/* rtl/core/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the double-ended queue engine: the command and
// result transaction layouts, opcodes, status codes and the cell shift modes.
// ----------------------------------------------------------------------------
package deq_pkg;

    // opcodes carried by a command transaction
    localparam logic [2:0] OP_SHOW_FWD   = 3'd0;
    localparam logic [2:0] OP_SHOW_REV   = 3'd1;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd3;
    localparam logic [2:0] OP_POP_FRONT  = 3'd4;
    localparam logic [2:0] OP_POP_BACK   = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // command transaction
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
    } t_deq_in;

    // result transaction
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
    } t_deq_out;

    // what every cell of the chain does at each clock edge
    typedef enum logic [1:0] {
        CM_HOLD  = 2'd0,  // keep contents
        CM_SHR   = 2'd1,  // take left neighbor, cell 0 takes insert data
        CM_SHL   = 2'd2,  // take right neighbor, tail cell takes insert data
        CM_WRITE = 2'd3   // cell just past the tail takes insert data
    } t_cell_mode;

endpackage

/* rtl/core/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue chain. Holds one element and loads from its
// left or right neighbor, or from the insert bus, as the broadcast mode says.
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int DATA_BITS = 32,
    parameter int CNT_W     = 5,
    parameter int IDX       = 0
) (
    input  logic                        i_clk,
    input  deq_pkg::t_cell_mode         i_mode,
    input  logic [CNT_W-1:0]            i_count,
    input  logic signed [DATA_BITS-1:0] i_left,
    input  logic signed [DATA_BITS-1:0] i_right,
    input  logic signed [DATA_BITS-1:0] i_ins,
    output logic signed [DATA_BITS-1:0] o_data
);
    import deq_pkg::*;

    logic signed [DATA_BITS-1:0] r_data;
    logic                        w_is_tail;
    logic                        w_is_next;

    // local position compares against the fill count
    assign w_is_tail = (i_count == CNT_W'(IDX + 1));
    assign w_is_next = (i_count == CNT_W'(IDX));

    // element register, no reset: contents are undefined until written
    always_ff @(posedge i_clk) begin
        case (i_mode)
            CM_HOLD: begin
                r_data <= r_data;
            end
            CM_SHR: begin
                r_data <= i_left;
            end
            CM_SHL: begin
                if (w_is_tail) begin
                    r_data <= i_ins;
                end else begin
                    r_data <= i_right;
                end
            end
            CM_WRITE: begin
                if (w_is_next) begin
                    r_data <= i_ins;
                end
            end
            default: begin
                r_data <= r_data;
            end
        endcase
    end

    assign o_data = r_data;

endmodule

/* rtl/core/double_ended_queue_engine.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_engine
// Bounded double-ended queue built as a chain of shifting cells, cell 0 being
// the front. Push/pop/clear give one result, a show streams all elements.
// ----------------------------------------------------------------------------
// results: every result is registered; push, pop and clear answer in the
//   cycle after the command is taken, a show first enters its show state
//   and from there streams one element per cycle
// busy: push, pop and clear keep busy low, so they can run back to back; a
//   show of n stored elements holds busy high while the cell chain rotates once
// reset: synchronous active low, empties the queue; cells keep no reset, and
//   results cannot be stalled: o_strobe marks each result for a single cycle
module double_ended_queue_engine #(
    parameter int DEPTH     = 16,
    parameter int DATA_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::t_deq_in  i_cmd,
    output logic              o_strobe,
    output deq_pkg::t_deq_out o_result
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [CNT_W-1:0]            r_remain, n_remain;
    logic                        r_rev, n_rev;
    logic                        r_strobe, n_strobe;
    t_deq_out                    r_result, n_result;

    t_cell_mode                  w_mode;
    logic signed [DATA_BITS-1:0] w_ins;
    logic signed [DATA_BITS-1:0] w_val;
    logic signed [DATA_BITS-1:0] w_front;
    logic signed [DATA_BITS-1:0] w_tail;
    logic [CNT_W-1:0]            w_count_m1;
    logic [IDX_W-1:0]            w_tail_idx;
    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    logic signed [DATA_BITS-1:0] w_cell [DEPTH];

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_BITS-1:0] w_left;
        logic signed [DATA_BITS-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_ins;
        end else begin : g_mid
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_cell[g+1];
        end
        deq_cell #(
            .DATA_BITS (DATA_BITS),
            .CNT_W     (CNT_W),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .i_ins   (w_ins),
            .o_data  (w_cell[g])
        );
    end

    // front and tail taps
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_tail_idx = w_count_m1[IDX_W-1:0];
    assign w_front    = w_cell[0];
    assign w_tail     = w_cell[w_tail_idx];

    assign w_val    = DATA_BITS'(i_cmd.value);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    // command decode and show sequencing
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_remain = r_remain;
        n_rev    = r_rev;
        n_strobe = 1'b0;
        n_result = '{status: ST_OK, element: '0, last: 1'b1};
        w_mode   = CM_HOLD;
        w_ins    = w_front;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.opcode)
                        OP_SHOW_FWD, OP_SHOW_REV: begin
                            if (w_empty) begin
                                n_strobe        = 1'b1;
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_state  = S_SHOW;
                                n_remain = r_count;
                                n_rev    = (i_cmd.opcode == OP_SHOW_REV);
                            end
                        end
                        OP_PUSH_FRONT: begin
                            n_strobe = 1'b1;
                            if (w_full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                w_mode  = CM_SHR;
                                w_ins   = w_val;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            if (w_full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                w_mode  = CM_WRITE;
                                w_ins   = w_val;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            n_strobe = 1'b1;
                            if (w_empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_result.element = 32'(w_front);
                                w_mode           = CM_SHL;
                                n_count          = w_count_m1;
                            end
                        end
                        OP_POP_BACK: begin
                            n_strobe = 1'b1;
                            if (w_empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_result.element = 32'(w_tail);
                                n_count          = w_count_m1;
                            end
                        end
                        OP_CLEAR: begin
                            n_strobe = 1'b1;
                            n_count  = '0;
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end
            S_SHOW: begin
                // emit one end and rotate the occupied cells one step
                n_strobe      = 1'b1;
                n_result.last = (r_remain == CNT_W'(1));
                if (r_rev) begin
                    n_result.element = 32'(w_tail);
                    w_mode           = CM_SHR;
                    w_ins            = w_tail;
                end else begin
                    n_result.element = 32'(w_front);
                    w_mode           = CM_SHL;
                    w_ins            = w_front;
                end
                n_remain = r_remain - CNT_W'(1);
                if (r_remain == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_remain <= '0;
            r_rev    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_rev    <= n_rev;
            r_strobe <= n_strobe;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // fill count stays within the chain
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // a push taken while full answers with full status
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (i_cmd.opcode == OP_PUSH_FRONT ||
            i_cmd.opcode == OP_PUSH_BACK))
        |=> (o_strobe && o_result.status == ST_FULL))
        else $error("push on full queue not flagged");

    // show sequencing never runs with nothing left to emit
    a_show_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |-> (r_remain != '0))
        else $error("show running with zero remaining");

    // a show leaves the fill count untouched
    a_show_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |=> (r_count == $past(r_count)))
        else $error("fill count changed during show");

    // error results always close their transaction
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |-> o_result.last)
        else $error("error result without last");

endmodule

/* bench/double_ended_queue_engine_test.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_engine_test
// Self-checking bench for the double-ended queue engine. Commands are sent
// through the start/busy handshake and mirrored in a behavioral deque that
// predicts every result. Results are checked in order as the strobe marks
// them. Directed cases cover the empty and full queue, both ends and the
// ignored opcode. Biased random traffic then fills, wraps and drains the queue.
// ----------------------------------------------------------------------------
module double_ended_queue_engine_test;

    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 100000;

    // opcode that the engine takes but ignores
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // traffic mix while the random part runs
    typedef enum logic [1:0] {
        MIX_FILL  = 2'd0,
        MIX_DRAIN = 2'd1,
        MIX_EVEN  = 2'd2
    } t_traffic_mix;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_deq_in  i_cmd;
    logic     o_strobe;
    t_deq_out o_result;

    // behavioral deque and the results it predicts
    logic signed [31:0] deq_slots [DEPTH];
    int                 deq_head;
    int                 deq_fill;
    t_deq_out           expected_results [$];

    int fail_count;
    int cycle_count;

    double_ended_queue_engine #(
        .DEPTH     (DEPTH),
        .DATA_BITS (32)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // queue one predicted result
    function automatic void expect_result(logic [1:0] status, logic signed [31:0] element,
                                          logic last);
        t_deq_out res;
        res.status  = status;
        res.element = element;
        res.last    = last;
        expected_results.push_back(res);
    endfunction

    // update the deque for one taken command and predict its results
    function automatic void predict_deq(t_deq_in cmd);
        int offset;
        case (cmd.opcode)
            OP_SHOW_FWD, OP_SHOW_REV: begin
                if (deq_fill == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int k = 0; k < deq_fill; k++) begin
                        offset = (cmd.opcode == OP_SHOW_FWD) ? k : deq_fill - 1 - k;
                        expect_result(ST_OK, deq_slots[(deq_head + offset) % DEPTH],
                                      k == deq_fill - 1);
                    end
                end
            end
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (deq_fill >= DEPTH) begin
                    expect_result(ST_FULL, '0, 1'b1);
                end else begin
                    if (cmd.opcode == OP_PUSH_FRONT) begin
                        deq_head = (deq_head + DEPTH - 1) % DEPTH;
                        deq_slots[deq_head] = cmd.value;
                    end else begin
                        deq_slots[(deq_head + deq_fill) % DEPTH] = cmd.value;
                    end
                    deq_fill++;
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (deq_fill == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    if (cmd.opcode == OP_POP_FRONT) begin
                        expect_result(ST_OK, deq_slots[deq_head], 1'b1);
                        deq_head = (deq_head + 1) % DEPTH;
                    end else begin
                        expect_result(ST_OK, deq_slots[(deq_head + deq_fill - 1) % DEPTH],
                                      1'b1);
                    end
                    deq_fill--;
                end
            end
            OP_CLEAR: begin
                deq_fill = 0;
                deq_head = 0;
                expect_result(ST_OK, '0, 1'b1);
            end
            default: begin
                // ignored opcode, nothing follows
            end
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin : result_check
        t_deq_out want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: status %0d element %0d last %0d",
                       o_result.status, o_result.element, o_result.last);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.element !== want.element) begin
                    $error("element: expected %0d actual %0d", want.element,
                           o_result.element);
                    fail_count++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d actual %0d", want.last, o_result.last);
                    fail_count++;
                end
            end
        end
    end

    // send one command and wait until it is taken
    task automatic send_cmd(input logic [2:0] opcode, input logic signed [31:0] value);
        t_deq_in cmd;
        cmd.opcode = opcode;
        cmd.value  = value;
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_deq(cmd);
    endtask

    // sender idles for a number of cycles
    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // sender holds off until every predicted result has come
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // random value, leaning on the extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // show and pop on an empty queue
    task automatic test_empty_queue();
        send_cmd(OP_SHOW_FWD, 32'sd5);
        send_cmd(OP_SHOW_REV, -32'sd5);
        send_cmd(OP_POP_FRONT, 32'sd0);
        send_cmd(OP_POP_BACK, 32'sd0);
    endtask

    // pushes at both ends with extreme values, shows, pops
    task automatic test_both_ends();
        send_cmd(OP_PUSH_FRONT, 32'sh7fff_ffff);
        send_cmd(OP_PUSH_BACK, 32'sh8000_0000);
        send_cmd(OP_PUSH_FRONT, -32'sd1);
        send_cmd(OP_PUSH_BACK, 32'sd0);
        send_cmd(OP_SHOW_FWD, 32'sd0);
        send_cmd(OP_SHOW_REV, 32'sd0);
        send_cmd(OP_POP_FRONT, 32'sd0);
        send_cmd(OP_POP_BACK, 32'sd0);
        send_cmd(OP_SHOW_FWD, 32'sd0);
    endtask

    // ignored opcode leaves state alone, clear empties
    task automatic test_ignored_and_clear();
        send_cmd(OP_UNUSED, -32'sd1);
        send_cmd(OP_SHOW_REV, 32'sd0);
        send_cmd(OP_CLEAR, 32'sh5a5a_5a5a);
        send_cmd(OP_SHOW_FWD, 32'sd0);
        send_cmd(OP_PUSH_BACK, 32'sh1234_5678);
        send_cmd(OP_POP_FRONT, 32'sd0);
    endtask

    // fill to full from random ends, overflow both ends, drain across the wrap
    task automatic test_full_and_wrap();
        while (deq_fill < DEPTH)
            send_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
        send_cmd(OP_PUSH_FRONT, 32'sd7);
        send_cmd(OP_PUSH_BACK, -32'sd7);
        send_cmd(OP_SHOW_FWD, 32'sd0);
        send_cmd(OP_SHOW_REV, 32'sd0);
        while (deq_fill > 0)
            send_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, 32'sd0);
        send_cmd(OP_SHOW_REV, 32'sd0);
    endtask

    // biased random traffic, sender gaps optional
    task automatic test_random_traffic(input int items, input bit with_gaps);
        t_traffic_mix mix;
        int           run_left;
        int           roll;
        int           sent;
        int           push_pct;
        int           pop_pct;
        logic [2:0]   opcode;
        sent     = 0;
        run_left = 0;
        mix      = MIX_EVEN;
        while (sent < items) begin
            if (run_left == 0) begin
                mix      = t_traffic_mix'($urandom_range(0, 2));
                run_left = $urandom_range(20, 40);
            end
            run_left--;
            case (mix)
                MIX_FILL:  begin push_pct = 70; pop_pct = 15; end
                MIX_DRAIN: begin push_pct = 20; pop_pct = 62; end
                default:   begin push_pct = 42; pop_pct = 42; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                opcode = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else if (roll < push_pct + pop_pct)
                opcode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            else if (roll < 96)
                opcode = $urandom_range(0, 1) ? OP_SHOW_FWD : OP_SHOW_REV;
            else if (roll < 98)
                opcode = OP_CLEAR;
            else
                opcode = OP_UNUSED;
            send_cmd(opcode, pick_value());
            if (opcode != OP_UNUSED)
                sent++;
            if (with_gaps && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 19));
        end
    endtask

    // main sequence
    initial begin
        fail_count = 0;
        deq_head   = 0;
        deq_fill   = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_both_ends();
        test_ignored_and_clear();
        wait_drained();
        test_full_and_wrap();
        test_random_traffic(160, 1'b1);
        wait_drained();
        pause_sender($urandom_range(1, 19));
        test_random_traffic(120, 1'b1);
        test_random_traffic(60, 1'b0);

        // let the last results come out
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue_engine.sv
bench/double_ended_queue_engine_test.sv
